FILE: hw/rtl/sbed_pkg.sv
package sbed_pkg;

  localparam int unsigned CfgW = 13;

  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_GOOD     = 2'd1;
  localparam logic [1:0] KIND_MISMATCH = 2'd2;
  localparam logic [1:0] KIND_CORRUPT  = 2'd3;

  localparam logic [1:0] MODE_DATA    = 2'd0;
  localparam logic [1:0] MODE_TRAILER = 2'd1;
  localparam logic [1:0] MODE_DEAD    = 2'd2;

  localparam logic [2:0] ESC_NONE    = 3'd0;
  localparam logic [2:0] ESC_MINUS40 = 3'd1;
  localparam logic [2:0] ESC_PLUS40A = 3'd2;
  localparam logic [2:0] ESC_PLUS40B = 3'd3;
  localparam logic [2:0] ESC_PLUS80  = 3'd4;
  localparam logic [2:0] ESC_PLUSC0  = 3'd5;

  localparam logic [2:0] TRAILER_DIGITS = 3'd4;
  localparam logic [15:0] SUM_INIT = 16'hffff;

  // classified line beat, front to back
  typedef struct packed {
    logic       start;
    logic [7:0] raw;
    logic       is_prefix;
    logic [2:0] pfx_code;
    logic       is_7e;
    logic       is_ctrl;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       is_cr;
  } beat_t;

endpackage

FILE: hw/rtl/sbed_fifo.sv
module sbed_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o,
  output logic             full_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: hw/rtl/sbed_front.sv
module sbed_front
  import sbed_pkg::*;
(
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       start_file_i,
  input  logic       q_full_i,
  output logic       push_o,
  output beat_t      beat_o
);

  logic [6:0] b;
  logic       is_digit, is_lower, is_upper;

  assign b        = rx_byte_i[6:0];
  assign is_digit = (rx_byte_i >= 8'h30) && (rx_byte_i <= 8'h39);
  assign is_lower = (rx_byte_i >= 8'h61) && (rx_byte_i <= 8'h66);
  assign is_upper = (rx_byte_i >= 8'h41) && (rx_byte_i <= 8'h46);

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    beat_o.start     = start_file_i;
    beat_o.raw       = rx_byte_i;
    beat_o.is_prefix = (b >= 7'h7a);
    beat_o.pfx_code  = b[2:0] - 3'd1;
    beat_o.is_7e     = (b == 7'h7e);
    beat_o.is_ctrl   = (b < 7'h20);
    beat_o.hex_ok    = is_digit || is_lower || is_upper;
    beat_o.hex_val   = is_digit ? rx_byte_i[3:0] : (rx_byte_i[3:0] + 4'd9);
    beat_o.is_cr     = (rx_byte_i == 8'h0d);
  end

endmodule

FILE: hw/rtl/sbed_back.sv
module sbed_back
  import sbed_pkg::*;
#(
  parameter int unsigned MaxPacket = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            q_empty_i,
  input  beat_t           beat_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      data_byte_o,
  output logic            last_in_packet_o
);

  localparam int unsigned CntW = $clog2(MaxPacket + 1);
  localparam int unsigned CmpW = (CntW > CfgW) ? CntW : CfgW;
  localparam int unsigned RstLimit = (MaxPacket < 256) ? MaxPacket : 256;

  logic [CntW-1:0] limit_q, limit_d;
  logic [CmpW-1:0] cfg_ext;
  logic [15:0]     sum_q, sum_d;
  logic [2:0]      esc_q, esc_d;
  logic [1:0]      mode_q, mode_d;
  logic [2:0]      tcnt_q, tcnt_d;
  logic [15:0]     tval_q, tval_d;
  logic [CntW-1:0] pcnt_q, pcnt_d;
  logic [CntW-1:0] pcnt_inc;
  logic [7:0]      c;
  logic            res_valid;
  logic [1:0]      res_kind;
  logic [7:0]      res_data;
  logic            res_last;
  logic            out_valid_q, out_valid_d;
  logic [1:0]      kind_q;
  logic [7:0]      data_q;
  logic            last_q;

  // clamp packet size once, at the write
  assign cfg_ext = CmpW'(cfg_data_i);
  always_comb begin
    limit_d = limit_q;
    if (cfg_we_i) begin
      if (cfg_ext == '0) begin
        limit_d = CntW'(1);
      end else if (cfg_ext > CmpW'(MaxPacket)) begin
        limit_d = CntW'(MaxPacket);
      end else begin
        limit_d = CntW'(cfg_ext);
      end
    end
  end

  assign pop_o = !q_empty_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    sum_d     = sum_q;
    esc_d     = esc_q;
    mode_d    = mode_q;
    tcnt_d    = tcnt_q;
    tval_d    = tval_q;
    pcnt_d    = pcnt_q;
    pcnt_inc  = '0;
    c         = {1'b0, beat_i.raw[6:0]};
    res_valid = 1'b0;
    res_kind  = KIND_DATA;
    res_data  = 8'h00;
    res_last  = 1'b0;
    if (pop_o) begin
      if (beat_i.start) begin
        sum_d  = SUM_INIT;
        esc_d  = ESC_NONE;
        mode_d = MODE_DATA;
        tcnt_d = 3'd0;
        tval_d = 16'h0000;
        pcnt_d = '0;
      end
      case (mode_d)
        MODE_TRAILER: begin
          if (tcnt_d < TRAILER_DIGITS) begin
            if (!beat_i.hex_ok) begin
              res_valid = 1'b1;
              res_kind  = KIND_CORRUPT;
            end else begin
              tval_d = {tval_d[11:0], beat_i.hex_val};
              tcnt_d = tcnt_d + 3'd1;
            end
          end else begin
            res_valid = 1'b1;
            if (!beat_i.is_cr) begin
              res_kind = KIND_CORRUPT;
            end else if (tval_d == sum_d) begin
              res_kind = KIND_GOOD;
            end else begin
              res_kind = KIND_MISMATCH;
            end
          end
        end
        MODE_DATA: begin
          if (beat_i.is_prefix) begin
            if (esc_d != ESC_NONE) begin
              if (esc_d != ESC_PLUSC0 || !beat_i.is_7e) begin
                res_valid = 1'b1;
                res_kind  = KIND_CORRUPT;
              end else begin
                esc_d  = ESC_NONE;
                mode_d = MODE_TRAILER;
                tcnt_d = 3'd0;
                tval_d = 16'h0000;
              end
            end else begin
              esc_d = beat_i.pfx_code;
            end
          end else if (beat_i.is_ctrl) begin
            res_valid = 1'b1;
            res_kind  = KIND_CORRUPT;
          end else begin
            case (esc_d)
              ESC_MINUS40: c = {1'b0, beat_i.raw[6:0]} - 8'h40;
              ESC_PLUS40A,
              ESC_PLUS40B: c = {1'b0, beat_i.raw[6:0]} + 8'h40;
              ESC_PLUS80:  c = {1'b0, beat_i.raw[6:0]} + 8'h80;
              ESC_PLUSC0:  c = {1'b0, beat_i.raw[6:0]} + 8'hc0;
              default:     c = {1'b0, beat_i.raw[6:0]};
            endcase
            esc_d    = ESC_NONE;
            sum_d    = {sum_d[14:0], sum_d[15]} + {8'h00, c};
            pcnt_inc = pcnt_d + CntW'(1);
            res_valid = 1'b1;
            res_data  = c;
            if (pcnt_inc >= limit_q) begin
              res_last = 1'b1;
              pcnt_d   = '0;
            end else begin
              pcnt_d = pcnt_inc;
            end
          end
        end
        default: begin
        end
      endcase
      if (res_valid && res_kind != KIND_DATA) begin
        mode_d = MODE_DEAD;
        esc_d  = ESC_NONE;
      end
    end
  end

  assign out_valid_d = pop_o ? res_valid : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= CntW'(RstLimit);
      sum_q       <= SUM_INIT;
      esc_q       <= ESC_NONE;
      mode_q      <= MODE_DATA;
      tcnt_q      <= 3'd0;
      tval_q      <= 16'h0000;
      pcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      limit_q     <= limit_d;
      sum_q       <= sum_d;
      esc_q       <= esc_d;
      mode_q      <= mode_d;
      tcnt_q      <= tcnt_d;
      tval_q      <= tval_d;
      pcnt_q      <= pcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && res_valid) begin
      kind_q <= res_kind;
      data_q <= res_data;
      last_q <= res_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign data_byte_o      = data_q;
  assign last_in_packet_o = last_q;

endmodule

FILE: hw/rtl/seven_bit_escape_decoder_checksum_unit.sv
// Seven-bit escape decoder with 16-bit rotate-and-add file checksum.
//
// Input channel: in_valid_i / in_stall_o carry rx_byte_i and start_file_i.
// A classifier feeds a two-entry queue; in_stall_o is high only when that
// queue is full. Output channel: out_valid_o / out_stall_i carry kind_o,
// data_byte_o and last_in_packet_o from a single output register.
// Config channel: cfg_valid_i / cfg_ready_o write cfg_packet_size_i;
// cfg_ready_o is always high.
//
// An accepted beat is written into the queue; the back end decodes it from the
// queue head and registers its result (if any) in the output register.
// Throughput: one beat per cycle while out_stall_i is low. A stalled output
// holds its result and stops the back end; the queue then fills and in_stall_o rises.
//
// Reset clears the queue, the output valid flag and all decode state; the
// checksum starts at 0xffff and the packet size at 256 (or MAX_PACKET if
// smaller). After an end or error result beats are dropped until a beat
// with start_file_i set.
module seven_bit_escape_decoder_checksum_unit
  import sbed_pkg::*;
#(
  parameter int unsigned MAX_PACKET = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      rx_byte_i,
  input  logic            start_file_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      data_byte_o,
  output logic            last_in_packet_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CfgW-1:0] cfg_packet_size_i
);

  beat_t push_beat, head_beat;
  logic  push, pop, q_empty, q_full;

  assign cfg_ready_o = 1'b1;

  sbed_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .start_file_i (start_file_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .beat_o       (push_beat)
  );

  sbed_fifo #(
    .Width ($bits(beat_t))
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_beat),
    .pop_i   (pop),
    .rdata_o (head_beat),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  sbed_back #(
    .MaxPacket (MAX_PACKET)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_data_i       (cfg_packet_size_i),
    .q_empty_i        (q_empty),
    .beat_i           (head_beat),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .data_byte_o      (data_byte_o),
    .last_in_packet_o (last_in_packet_o)
  );

endmodule

FILE: hw/rtl/sbed_checker.sv
module sbed_checker
  import sbed_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] kind_o,
  input logic [7:0] data_byte_o,
  input logic       last_in_packet_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(kind_o) && $stable(data_byte_o)
      && $stable(last_in_packet_o))
    else $error("stalled output beat changed");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_DATA |-> data_byte_o == 8'h00 && !last_in_packet_o)
    else $error("status beat carries data");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind seven_bit_escape_decoder_checksum_unit sbed_checker u_sbed_checker (.*);

FILE: bench/seven_bit_escape_decoder_checksum_unit_tb.sv
`timescale 1ns / 100ps

module seven_bit_escape_decoder_checksum_unit_tb;
  import sbed_pkg::*;

  localparam int unsigned PKT_MAX = 4096;
  localparam logic [6:0] PFX_LOW = 7'h7a;
  localparam logic [6:0] PFX_TRAILER = 7'h7e;
  localparam logic [6:0] PRINT_LOW = 7'h20;
  localparam logic [6:0] PRINT_HIGH = 7'h79;
  localparam logic [7:0] LINE_CR = 8'h0d;

  typedef enum int unsigned {
    END_GOOD, END_MISMATCH, END_BAD_DIGIT, END_BAD_CR,
    END_CTRL, END_PREFIX_PAIR, END_OPEN, END_NOISE
  } file_end_e;

  typedef struct packed {
    logic [7:0] raw;
    logic       sof;
  } line_beat_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       pkt_end;
  } line_result_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic [7:0]      rx_byte_i = 8'h00;
  logic            start_file_i = 1'b0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [1:0]      kind_o;
  logic [7:0]      data_byte_o;
  logic            last_in_packet_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [CfgW-1:0] cfg_packet_size_i = '0;

  seven_bit_escape_decoder_checksum_unit #(
    .MAX_PACKET(PKT_MAX)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .start_file_i     (start_file_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .data_byte_o      (data_byte_o),
    .last_in_packet_o (last_in_packet_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_packet_size_i(cfg_packet_size_i)
  );

  // predicted decoder state
  logic [15:0]     file_sum = SUM_INIT;
  logic [2:0]      esc_code = ESC_NONE;
  logic [1:0]      dec_mode = MODE_DATA;
  logic [2:0]      trl_count = '0;
  logic [15:0]     trl_value = '0;
  int unsigned     pkt_count = 0;
  logic [CfgW-1:0] pkt_size = 13'd256;

  line_beat_t   line_q[$];
  line_result_t decoded_q[$];
  line_beat_t   drv_beat;
  line_result_t want;

  bit          rx_taken = 1'b0;
  bit          rx_calm = 1'b0;
  bit          tx_calm = 1'b1;
  int unsigned rx_gap = 0;
  int unsigned tx_hold = 0;

  int          errors = 0;
  int unsigned stim_count = 0;
  int unsigned n_data = 0;
  int unsigned n_good = 0;
  int unsigned n_mism = 0;
  int unsigned n_corrupt = 0;

  logic        sof_next = 1'b0;
  logic [15:0] gen_sum = SUM_INIT;
  int unsigned sizes[8];

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic int unsigned draw_wait(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic logic [2:0] prefix_code(input logic [6:0] b);
    return 3'(b - 7'h79);
  endfunction

  function automatic logic [7:0] unescape(input logic [2:0] code, input logic [6:0] b);
    case (code)
      ESC_MINUS40: return {1'b0, b} - 8'h40;
      ESC_PLUS40A, ESC_PLUS40B: return {1'b0, b} + 8'h40;
      ESC_PLUS80: return {1'b0, b} + 8'h80;
      ESC_PLUSC0: return {1'b0, b} + 8'hc0;
      default: return {1'b0, b};
    endcase
  endfunction

  function automatic logic [15:0] fold_sum(input logic [15:0] s, input logic [7:0] c);
    return {s[14:0], s[15]} + {8'h00, c};
  endfunction

  function automatic logic hex_digit(input logic [7:0] raw, output logic [3:0] nib);
    nib = 4'h0;
    if (raw >= "0" && raw <= "9") begin
      nib = 4'(raw - "0");
      return 1'b1;
    end
    if (raw >= "a" && raw <= "f") begin
      nib = 4'(raw - "a" + 10);
      return 1'b1;
    end
    if (raw >= "A" && raw <= "F") begin
      nib = 4'(raw - "A" + 10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'("0" + nib);
    return 8'((rand_bit() ? "a" : "A") + nib - 10);
  endfunction

  task automatic post_result(input logic [1:0] kind, input logic [7:0] data, input logic pkt_end);
    line_result_t r;
    r.kind = kind;
    r.data = data;
    r.pkt_end = pkt_end;
    decoded_q.push_back(r);
    case (kind)
      KIND_DATA: n_data++;
      KIND_GOOD: n_good++;
      KIND_MISMATCH: n_mism++;
      default: n_corrupt++;
    endcase
  endtask

  task automatic go_dead(input logic [1:0] kind);
    dec_mode = MODE_DEAD;
    esc_code = ESC_NONE;
    post_result(kind, 8'h00, 1'b0);
  endtask

  task automatic decode_line_byte(input logic [7:0] raw, input logic sof);
    logic [6:0]  b;
    logic [7:0]  c;
    logic [3:0]  nib;
    int unsigned lim;
    b = raw[6:0];
    if (sof) begin
      file_sum = SUM_INIT;
      esc_code = ESC_NONE;
      dec_mode = MODE_DATA;
      trl_count = '0;
      trl_value = '0;
      pkt_count = 0;
    end
    if (dec_mode == MODE_TRAILER) begin
      if (trl_count < TRAILER_DIGITS) begin
        if (!hex_digit(raw, nib)) begin
          go_dead(KIND_CORRUPT);
        end else begin
          trl_value = {trl_value[11:0], nib};
          trl_count++;
        end
      end else if (raw != LINE_CR) begin
        go_dead(KIND_CORRUPT);
      end else begin
        go_dead(trl_value == file_sum ? KIND_GOOD : KIND_MISMATCH);
      end
    end else if (dec_mode == MODE_DATA) begin
      if (b >= PFX_LOW) begin
        if (esc_code != ESC_NONE) begin
          if (esc_code != ESC_PLUSC0 || b != PFX_TRAILER) begin
            go_dead(KIND_CORRUPT);
          end else begin
            esc_code = ESC_NONE;
            dec_mode = MODE_TRAILER;
            trl_count = '0;
            trl_value = '0;
          end
        end else begin
          esc_code = prefix_code(b);
        end
      end else if (b < PRINT_LOW) begin
        go_dead(KIND_CORRUPT);
      end else begin
        c = unescape(esc_code, b);
        esc_code = ESC_NONE;
        file_sum = fold_sum(file_sum, c);
        lim = (pkt_size == 0) ? 1 : (pkt_size > PKT_MAX ? PKT_MAX : pkt_size);
        pkt_count++;
        if (pkt_count >= lim) begin
          pkt_count = 0;
          post_result(KIND_DATA, c, 1'b1);
        end else begin
          post_result(KIND_DATA, c, 1'b0);
        end
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_v, input int unsigned got);
    if (exp_v != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got);
    end
  endtask

  // stimulus builders
  task automatic push_raw(input logic [7:0] raw);
    line_beat_t lb;
    lb.raw = raw;
    lb.sof = sof_next;
    sof_next = 1'b0;
    line_q.push_back(lb);
  endtask

  task automatic push_beat(input logic [7:0] raw);
    push_raw(raw);
    stim_count++;
  endtask

  task automatic push_char(input logic has_pfx, input logic [7:0] pfx, input logic [7:0] ch);
    if (has_pfx) push_beat(pfx);
    push_beat(ch);
    gen_sum = fold_sum(gen_sum, unescape(has_pfx ? prefix_code(pfx[6:0]) : ESC_NONE, ch[6:0]));
  endtask

  task automatic push_random_char();
    logic [7:0] pfx;
    logic [7:0] ch;
    pfx = {rand_bit(), 7'(PFX_LOW + $urandom_range(0, 5))};
    ch = {rand_bit(), 7'($urandom_range(PRINT_LOW, PRINT_HIGH))};
    push_char($urandom_range(0, 9) < 3, pfx, ch);
  endtask

  task automatic push_trailer(input logic [15:0] val, input int unsigned n_dig,
                              input bit with_cr, input logic [7:0] cr);
    push_beat({rand_bit(), PFX_TRAILER});
    push_beat({rand_bit(), PFX_TRAILER});
    for (int i = 0; i < n_dig; i++) push_beat(hex_char(val[15 - 4 * i -: 4]));
    if (with_cr) push_beat(cr);
  endtask

  task automatic queue_file(input int unsigned len, input file_end_e ending);
    logic [7:0] bad;
    logic [3:0] nib;
    int unsigned p1;
    int unsigned p2;
    sof_next = 1'b1;
    gen_sum = SUM_INIT;
    repeat (len) push_random_char();
    case (ending)
      END_GOOD: push_trailer(gen_sum, 4, 1'b1, LINE_CR);
      END_MISMATCH: push_trailer(gen_sum ^ 16'($urandom_range(1, 65535)), 4, 1'b1, LINE_CR);
      END_BAD_DIGIT: begin
        if (rand_bit()) begin
          bad = hex_char(4'($urandom)) | 8'h80;
        end else begin
          do bad = 8'($urandom); while (hex_digit(bad, nib));
        end
        push_trailer(gen_sum, $urandom_range(0, 3), 1'b0, LINE_CR);
        push_beat(bad);
      end
      END_BAD_CR: begin
        if (rand_bit()) bad = LINE_CR | 8'h80;
        else do bad = 8'($urandom); while (bad == LINE_CR);
        push_trailer(gen_sum, 4, 1'b1, bad);
      end
      END_CTRL: begin
        if (rand_bit()) push_beat({rand_bit(), 7'(PFX_LOW + $urandom_range(0, 5))});
        push_beat({rand_bit(), 7'($urandom_range(0, 31))});
      end
      END_PREFIX_PAIR: begin
        do begin
          p1 = $urandom_range(0, 5);
          p2 = $urandom_range(0, 5);
        end while (PFX_LOW + p1 == PFX_TRAILER && PFX_LOW + p2 == PFX_TRAILER);
        push_beat({rand_bit(), 7'(PFX_LOW + p1)});
        push_beat({rand_bit(), 7'(PFX_LOW + p2)});
      end
      END_OPEN: begin
        // file abandoned: the next start_file cuts it off
        case ($urandom_range(0, 2))
          0: ;
          1: push_beat({rand_bit(), 7'(PFX_LOW + $urandom_range(0, 5))});
          default: push_trailer(gen_sum, $urandom_range(0, 4), 1'b0, LINE_CR);
        endcase
      end
      default: repeat ($urandom_range(1, 10)) push_beat(8'($urandom));
    endcase
  endtask

  task automatic queue_phase(input int unsigned n_items, input bit with_long);
    int unsigned stop;
    int unsigned len;
    int unsigned pick;
    file_end_e   ending;
    stop = stim_count + n_items;
    if (with_long) queue_file(270, END_GOOD);
    while (stim_count < stop) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(0, 24);
      pick = $urandom_range(0, 99);
      if (pick < 45) ending = END_GOOD;
      else if (pick < 55) ending = END_MISMATCH;
      else if (pick < 63) ending = END_BAD_DIGIT;
      else if (pick < 70) ending = END_BAD_CR;
      else if (pick < 78) ending = END_CTRL;
      else if (pick < 85) ending = END_PREFIX_PAIR;
      else if (pick < 94) ending = END_OPEN;
      else ending = END_NOISE;
      queue_file(len, ending);
      repeat ($urandom_range(0, 3)) push_raw(8'($urandom));
    end
  endtask

  task automatic settle();
    while (line_q.size() != 0 || in_valid_i || decoded_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_packet_size(input logic [CfgW-1:0] v);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_packet_size_i = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // line byte driver
  always @(negedge clk_i) begin
    if (!in_valid_i || rx_taken) begin
      if (rx_gap > 0) begin
        in_valid_i <= 1'b0;
        rx_gap--;
      end else if (line_q.size() > 0) begin
        drv_beat = line_q.pop_front();
        rx_byte_i <= drv_beat.raw;
        start_file_i <= drv_beat.sof;
        in_valid_i <= 1'b1;
        rx_gap = draw_wait(rx_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk_i) begin
    out_stall_i <= (tx_hold > 0);
    if (tx_hold > 0 && out_valid_o) tx_hold--;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) pkt_size = cfg_packet_size_i;
      if (out_valid_o && !out_stall_i) begin
        tx_hold = draw_wait(tx_calm);
        if (decoded_q.size() == 0) begin
          errors++;
          $display("%0t: beat with nothing expected, actual kind %0h data %0h end %0h",
                   $time, kind_o, data_byte_o, last_in_packet_o);
        end else begin
          want = decoded_q.pop_front();
          check_field("kind", want.kind, kind_o);
          check_field("data_byte", want.data, data_byte_o);
          check_field("last_in_packet", want.pkt_end, last_in_packet_o);
        end
      end
      rx_taken = in_valid_i && !in_stall_o;
      if (rx_taken) decode_line_byte(rx_byte_i, start_file_i);
    end
  end

  initial begin
    sizes = '{1, 0, 3, 0, 4096, 8191, 256, 7};
    sizes[3] = $urandom_range(2, 24);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // every escape prefix, wrap in both directions, good trailer
    sof_next = 1'b1;
    gen_sum = SUM_INIT;
    push_char(1'b0, 8'h00, 8'h20);
    push_char(1'b0, 8'h00, 8'hf9);
    push_char(1'b1, 8'h7a, 8'h20);
    push_char(1'b1, 8'h7b, 8'h79);
    push_char(1'b1, 8'h7c, 8'h41);
    push_char(1'b1, 8'hfd, 8'h50);
    push_char(1'b1, 8'h7e, 8'h79);
    push_char(1'b1, 8'h7f, 8'h30);
    push_trailer(gen_sum, 4, 1'b1, LINE_CR);
    push_beat(8'h41);
    // prefix pair, then control byte behind a pending prefix
    sof_next = 1'b1;
    push_beat(8'h7a);
    push_beat(8'h7b);
    sof_next = 1'b1;
    push_beat(8'h7e);
    push_beat(8'h9f);
    settle();

    for (int i = 0; i < 8; i++) begin
      set_packet_size(CfgW'(sizes[i]));
      queue_phase(80, sizes[i] == 256);
      settle();
    end

    repeat (8) @(posedge clk_i);
    $display("%0d line bytes over eight packet sizes (0 to 8191) and reset size 256", stim_count);
    $display("results: %0d data, %0d good end, %0d mismatch, %0d corrupt",
             n_data, n_good, n_mism, n_corrupt);
    if (errors == 0) begin
      $display("seven_bit_escape_decoder_checksum_unit_tb: clean");
    end else begin
      $display("seven_bit_escape_decoder_checksum_unit_tb: errors");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("seven_bit_escape_decoder_checksum_unit_tb: errors");
    $finish;
  end

endmodule
